/* rtl/vn2d_pkg.sv */
// shared constants, types and helpers for the 2-d value noise pipeline
package vn2d_pkg;

    localparam int COORD_W       = 17;
    localparam int NOISE_W       = 16;
    localparam int FRAC_BITS_DEF = 8;
    localparam int WEIGHT_W      = 17;
    localparam int HASH_W        = 32;

    localparam logic [HASH_W-1:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [HASH_W-1:0] HASH_MUL_Y   = 32'd668265263;
    localparam logic [HASH_W-1:0] HASH_MUL_MIX = 32'd1274126177;

    // 1.0 in q1.16 and the rounding constant for a >> 32
    localparam logic [WEIGHT_W-1:0] ONE_Q16    = 17'h10000;
    localparam logic [49:0]         ROUND_W    = 50'h0_8000_0000;
    localparam logic [47:0]         ROUND_OUT  = 48'h0000_8000_0000;
    // 3.0 in q2.16, the constant term of the smoothstep polynomial
    localparam logic [17:0]         THREE_Q16  = 18'h30000;

    // per-stage load enables handed to the datapath modules
    typedef struct packed {
        logic st2;
        logic st3;
        logic st4;
        logic st5;
        logic st6;
    } stage_en_t;

    // final hash fold, low half of h ^ (h >> 16)
    function automatic logic [NOISE_W-1:0] hash_fold(input logic [HASH_W-1:0] h);
        hash_fold = h[15:0] ^ h[31:16];
    endfunction

endpackage

/* rtl/value_noise_2d_core.sv */
// top level of the 2-d value noise pipeline
//
// usage:
// - input channel s_valid/s_ready carries one sample beat: s_x_coord and
//   s_y_coord, signed fixed point with FRAC_BITS fraction bits
// - result channel m_valid/m_ready carries m_noise_value, an unsigned q0.16
//   fraction where 65536 stands for 1.0
// - six register stages: split, axis products, corner sums and weights,
//   mix multiply, row blends, output register
// - one beat per cycle sustained while m_ready is high; each stage after the
//   split is bounded by multipliers (axis products, hash mix, smoothstep or blend)
// - every stage has its own valid bit and loads when it is empty or its
//   successor moves, so bubbles are squeezed out on a stall
// - when the receiver holds m_ready low the output register keeps its beat
//   and earlier stages keep filling; s_ready falls only once all stages
//   hold valid beats
// - reset (aresetn low at a clock edge) clears all valid bits; data
//   registers are not reset
module value_noise_2d_core
    import vn2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_x_coord,
    input  logic signed [COORD_W-1:0] s_y_coord,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [NOISE_W-1:0]        m_noise_value
);

    localparam int CELL_W    = COORD_W - FRAC_BITS;
    localparam int NUM_STAGE = 6;

    // stage valid bits and load enables, index 1 is the split stage
    logic [NUM_STAGE:1]   valid_reg, valid_next;
    logic [NUM_STAGE+1:1] ld;
    stage_en_t            en;

    // stage 1 payload
    logic signed [CELL_W-1:0] cx_next, cy_next, cx_reg, cy_reg;
    logic [15:0]              tx_next, ty_next, tx_reg, ty_reg;

    logic [HASH_W-1:0]   mix00, mix10, mix01, mix11;
    logic [WEIGHT_W-1:0] w_x, w_y;

    // a stage loads when empty or when its successor loads
    always_comb begin
        ld[NUM_STAGE+1] = m_ready;
        for (int k = NUM_STAGE; k >= 1; k--) begin
            ld[k] = !valid_reg[k] || ld[k+1];
        end
    end

    always_comb begin
        valid_next[1] = ld[1] ? s_valid : valid_reg[1];
        for (int k = 2; k <= NUM_STAGE; k++) begin
            valid_next[k] = ld[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign en.st2 = ld[2];
    assign en.st3 = ld[3];
    assign en.st4 = ld[4];
    assign en.st5 = ld[5];
    assign en.st6 = ld[6];

    // stage 1: floor is an arithmetic shift, fraction widened to q0.16
    assign cx_next = s_x_coord[COORD_W-1:FRAC_BITS];
    assign cy_next = s_y_coord[COORD_W-1:FRAC_BITS];
    assign tx_next = 16'(s_x_coord[FRAC_BITS-1:0]) << (16 - FRAC_BITS);
    assign ty_next = 16'(s_y_coord[FRAC_BITS-1:0]) << (16 - FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            tx_reg <= tx_next;
            ty_reg <= ty_next;
        end
    end

    // stages 2 to 4: corner hashes
    vn2d_hash #(
        .CELL_W (CELL_W)
    ) u_hash (
        .aclk   (aclk),
        .en     (en),
        .cell_x (cx_reg),
        .cell_y (cy_reg),
        .mix00  (mix00),
        .mix10  (mix10),
        .mix01  (mix01),
        .mix11  (mix11)
    );

    // stages 2 to 4: smoothstep weights, aligned with the hashes
    vn2d_smooth u_smooth (
        .aclk (aclk),
        .en   (en),
        .t_x  (tx_reg),
        .t_y  (ty_reg),
        .w_x  (w_x),
        .w_y  (w_y)
    );

    // stages 5 and 6: blend, output register
    vn2d_blend u_blend (
        .aclk  (aclk),
        .en    (en),
        .mix00 (mix00),
        .mix10 (mix10),
        .mix01 (mix01),
        .mix11 (mix11),
        .w_x   (w_x),
        .w_y   (w_y),
        .noise (m_noise_value)
    );

    assign s_ready = ld[1];
    assign m_valid = valid_reg[NUM_STAGE];

endmodule

/* rtl/vn2d_hash.sv */
// corner hash pipeline: axis products, corner sums, mix multiply
module vn2d_hash
    import vn2d_pkg::*;
#(
    parameter int CELL_W = COORD_W - FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  stage_en_t                en,
    input  logic signed [CELL_W-1:0] cell_x,
    input  logic signed [CELL_W-1:0] cell_y,
    output logic [HASH_W-1:0]        mix00,
    output logic [HASH_W-1:0]        mix10,
    output logic [HASH_W-1:0]        mix01,
    output logic [HASH_W-1:0]        mix11
);

    logic [HASH_W-1:0] cx_ext, cy_ext;
    logic [HASH_W-1:0] px_next, py_next, px_reg, py_reg;
    logic [HASH_W-1:0] h00_next, h10_next, h01_next, h11_next;
    logic [HASH_W-1:0] h00_reg, h10_reg, h01_reg, h11_reg;
    logic [HASH_W-1:0] m00_next, m10_next, m01_next, m11_next;
    logic [HASH_W-1:0] m00_reg, m10_reg, m01_reg, m11_reg;
    logic [HASH_W-1:0] px1, py1;

    // stage 2: per-axis products, wrap modulo 2^32
    assign cx_ext  = HASH_W'(cell_x);
    assign cy_ext  = HASH_W'(cell_y);
    assign px_next = HASH_W'(cx_ext * HASH_MUL_X);
    assign py_next = HASH_W'(cy_ext * HASH_MUL_Y);

    // stage 3: (c+1)*k is c*k + k
    assign px1      = px_reg + HASH_MUL_X;
    assign py1      = py_reg + HASH_MUL_Y;
    assign h00_next = px_reg + py_reg;
    assign h10_next = px1 + py_reg;
    assign h01_next = px_reg + py1;
    assign h11_next = px1 + py1;

    // stage 4: xor-shift then mix multiply
    assign m00_next = HASH_W'((h00_reg ^ (h00_reg >> 13)) * HASH_MUL_MIX);
    assign m10_next = HASH_W'((h10_reg ^ (h10_reg >> 13)) * HASH_MUL_MIX);
    assign m01_next = HASH_W'((h01_reg ^ (h01_reg >> 13)) * HASH_MUL_MIX);
    assign m11_next = HASH_W'((h11_reg ^ (h11_reg >> 13)) * HASH_MUL_MIX);

    always_ff @(posedge aclk) begin
        if (en.st2) begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (en.st3) begin
            h00_reg <= h00_next;
            h10_reg <= h10_next;
            h01_reg <= h01_next;
            h11_reg <= h11_next;
        end
        if (en.st4) begin
            m00_reg <= m00_next;
            m10_reg <= m10_next;
            m01_reg <= m01_next;
            m11_reg <= m11_next;
        end
    end

    assign mix00 = m00_reg;
    assign mix10 = m10_reg;
    assign mix01 = m01_reg;
    assign mix11 = m11_reg;

endmodule

/* rtl/vn2d_smooth.sv */
// smoothstep weight pipeline: t*t, then t*t*(3-2t) rounded, then carry
module vn2d_smooth
    import vn2d_pkg::*;
(
    input  logic                aclk,
    input  stage_en_t           en,
    input  logic [15:0]         t_x,
    input  logic [15:0]         t_y,
    output logic [WEIGHT_W-1:0] w_x,
    output logic [WEIGHT_W-1:0] w_y
);

    logic [31:0]         ttx_next, tty_next, ttx_reg, tty_reg;
    logic [15:0]         tx_reg, ty_reg;
    logic [17:0]         kx, ky;
    logic [49:0]         px, py;
    logic [WEIGHT_W-1:0] wx_next, wy_next, wx3_reg, wy3_reg, wx4_reg, wy4_reg;

    // stage 2: square
    assign ttx_next = 32'(t_x) * 32'(t_x);
    assign tty_next = 32'(t_y) * 32'(t_y);

    // stage 3: times (3 - 2t), round half up, drop 32 fraction bits
    assign kx      = THREE_Q16 - {1'b0, tx_reg, 1'b0};
    assign ky      = THREE_Q16 - {1'b0, ty_reg, 1'b0};
    assign px      = 50'(ttx_reg) * 50'(kx) + ROUND_W;
    assign py      = 50'(tty_reg) * 50'(ky) + ROUND_W;
    assign wx_next = px[48:32];
    assign wy_next = py[48:32];

    always_ff @(posedge aclk) begin
        if (en.st2) begin
            ttx_reg <= ttx_next;
            tty_reg <= tty_next;
            tx_reg  <= t_x;
            ty_reg  <= t_y;
        end
        if (en.st3) begin
            wx3_reg <= wx_next;
            wy3_reg <= wy_next;
        end
        if (en.st4) begin
            wx4_reg <= wx3_reg;
            wy4_reg <= wy3_reg;
        end
    end

    assign w_x = wx4_reg;
    assign w_y = wy4_reg;

endmodule

/* rtl/vn2d_blend.sv */
// bilinear blend: row lerps along x, then column lerp along y with rounding
module vn2d_blend
    import vn2d_pkg::*;
(
    input  logic                aclk,
    input  stage_en_t           en,
    input  logic [HASH_W-1:0]   mix00,
    input  logic [HASH_W-1:0]   mix10,
    input  logic [HASH_W-1:0]   mix01,
    input  logic [HASH_W-1:0]   mix11,
    input  logic [WEIGHT_W-1:0] w_x,
    input  logic [WEIGHT_W-1:0] w_y,
    output logic [NOISE_W-1:0]  noise
);

    logic [NOISE_W-1:0]  v00, v10, v01, v11;
    logic [WEIGHT_W-1:0] inv_wx, inv_wy;
    logic [31:0]         a_next, b_next, a_reg, b_reg;
    logic [WEIGHT_W-1:0] wy_reg;
    logic [47:0]         r_full;
    logic [NOISE_W-1:0]  noise_next, noise_reg;

    // stage 5: corner values and row blends, exact in q0.32
    assign v00    = hash_fold(mix00);
    assign v10    = hash_fold(mix10);
    assign v01    = hash_fold(mix01);
    assign v11    = hash_fold(mix11);
    assign inv_wx = ONE_Q16 - w_x;
    assign a_next = 32'(33'(v00) * 33'(inv_wx) + 33'(v10) * 33'(w_x));
    assign b_next = 32'(33'(v01) * 33'(inv_wx) + 33'(v11) * 33'(w_x));

    // stage 6: blend rows, round half up
    assign inv_wy     = ONE_Q16 - wy_reg;
    assign r_full     = 48'(a_reg) * 48'(inv_wy) + 48'(b_reg) * 48'(wy_reg) + ROUND_OUT;
    assign noise_next = r_full[47:32];

    always_ff @(posedge aclk) begin
        if (en.st5) begin
            a_reg  <= a_next;
            b_reg  <= b_next;
            wy_reg <= w_y;
        end
        if (en.st6) begin
            noise_reg <= noise_next;
        end
    end

    assign noise = noise_reg;

endmodule
